/* rtl/tmh_pkg.sv */
package tmh_pkg;

	localparam int CAPACITY_DEF  = 256;
	localparam int HANDLES_DEF   = 256;
	localparam int TIME_BITS_DEF = 32;

	localparam int ACTION_W = 3;
	localparam int HANDLE_W = 8;
	localparam int DELAY_W  = 31;
	localparam int NOW_W    = 32;
	localparam int STATUS_W = 3;
	localparam int EXPIRY_W = 32;
	localparam int COUNT_W  = 9;
	localparam int LIMIT_W  = 6;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd9;

	localparam int MAX_RESULTS = 64;
	localparam int RES_DEPTH   = 128;
	localparam int RES_AW      = 7;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SWEEP  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_END     = 3'd4;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic [EXPIRY_W-1:0] expiry;
		logic                last;
	} res_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [EXPIRY_W-1:0] min_expiry;
	} sum_t;

	typedef struct packed {
		logic res_we;
		res_t res;
		logic sum_we;
		sum_t sum;
	} wr_t;

endpackage

/* rtl/tmh_if.sv */
interface tmh_req_if;
	import tmh_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [HANDLE_W-1:0] handle;
	logic [DELAY_W-1:0]  delay;
	logic [NOW_W-1:0]    now;
	modport source (output valid, action, handle, delay, now, input ready);
	modport sink (input valid, action, handle, delay, now, output ready);
endinterface

interface tmh_rsp_if;
	import tmh_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] out_handle;
	logic [EXPIRY_W-1:0] out_expiry;
	logic                last;
	logic [COUNT_W-1:0]  heap_count;
	logic [EXPIRY_W-1:0] min_expiry;
	modport source (output valid, status, out_handle, out_expiry, last, heap_count,
		min_expiry, input ready);
	modport sink (input valid, status, out_handle, out_expiry, last, heap_count,
		min_expiry, output ready);
endinterface

/* rtl/tmh_ctrl.sv */
module tmh_ctrl #(
	parameter int CAPACITY  = tmh_pkg::CAPACITY_DEF,
	parameter int HANDLES   = tmh_pkg::HANDLES_DEF,
	parameter int TIME_BITS = tmh_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tmh_req_if.sink                      req,
	input  logic                         cfg_we,
	input  logic [tmh_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  logic                         room,
	output tmh_pkg::wr_t                 wr
);
	import tmh_pkg::*;

	localparam int HB  = $clog2(HANDLES);
	localparam int PB  = $clog2(CAPACITY + 1);
	localparam int HXW = ((HB > HANDLE_W) ? HB : HANDLE_W) + 1;
	localparam int EW  = (TIME_BITS > NOW_W + 1) ? TIME_BITS : NOW_W + 1;

	typedef struct packed {
		logic [HB-1:0]        h;
		logic [TIME_BITS-1:0] k;
	} ent_t;

	typedef enum logic [15:0] {
		S_CLR    = 16'h0001,
		S_IDLE   = 16'h0002,
		S_POS    = 16'h0004,
		S_DEC    = 16'h0008,
		S_INSX   = 16'h0010,
		S_RMX    = 16'h0020,
		S_RMLAST = 16'h0040,
		S_RS     = 16'h0080,
		S_UP     = 16'h0100,
		S_DN     = 16'h0200,
		S_DL     = 16'h0400,
		S_DR     = 16'h0800,
		S_FIN    = 16'h1000,
		S_SWCHK  = 16'h2000,
		S_SWX    = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	ent_t        heap_mem [CAPACITY+1];
	logic [PB-1:0] pos_mem [HANDLES];

	state_t               state_q, state_d;
	logic [ACTION_W-1:0]  act_q, act_d;
	logic [HANDLE_W-1:0]  hin_q, hin_d;
	logic [HB-1:0]        hx_q, hx_d, clr_q, clr_d;
	logic                 hok_q, hok_d, first_q, first_d;
	logic [TIME_BITS-1:0] ex_q, ex_d, root_q;
	logic [NOW_W-1:0]     now_q, now_d;
	logic [PB-1:0]        cnt_q, cnt_d, i_q, i_d, p_q, p_d;
	logic [LIMIT_W-1:0]   lim_q, done_q, done_d;
	ent_t                 e_q, e_d, left_q, left_d;

	ent_t                 h_rdata_q;
	logic [PB-1:0]        p_rdata_q;
	logic                 hw_we, hr_re, pw_we, pr_re;
	logic [PB-1:0]        hw_addr, hr_addr, pw_data, posv, newcnt;
	logic [HB-1:0]        pw_addr;
	ent_t                 hw_data, c_ent;
	logic [PB:0]          li, c_idx;
	logic [EW-1:0]        sum_w, tmax, ex_sat;
	logic [HXW-1:0]       hxe;
	logic                 expired, is_sweep;
	wr_t                  wr_d;

	function automatic res_t mk(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] h,
		logic [EXPIRY_W-1:0] x, logic l);
		res_t r;
		r.status = st;
		r.handle = h;
		r.expiry = x;
		r.last   = l;
		return r;
	endfunction

	function automatic logic [HANDLE_W-1:0] hout(logic [HB-1:0] h);
		logic [HXW-1:0] t;
		t = HXW'(h);
		return t[HANDLE_W-1:0];
	endfunction

	assign req.ready = (state_q == S_IDLE) && room;
	assign wr        = wr_d;

	assign sum_w  = EW'(req.now) + EW'(req.delay);
	assign tmax   = EW'({TIME_BITS{1'b1}});
	assign ex_sat = (sum_w > tmax) ? tmax : sum_w;
	assign hxe    = HXW'(req.handle);

	assign li       = {i_q, 1'b0};
	assign posv     = (!hok_q || p_rdata_q > cnt_q) ? '0 : p_rdata_q;
	assign newcnt   = cnt_q - PB'(1);
	assign expired  = EW'(h_rdata_q.k) <= EW'(now_q);
	assign is_sweep = (act_q == ACT_SWEEP);

	always_comb begin
		if (left_q.k > h_rdata_q.k) begin
			c_ent = h_rdata_q;
			c_idx = {i_q, 1'b1};
		end else begin
			c_ent = left_q;
			c_idx = li;
		end
	end

	always_comb begin
		state_d = state_q;
		act_d   = act_q;
		hin_d   = hin_q;
		hx_d    = hx_q;
		hok_d   = hok_q;
		ex_d    = ex_q;
		now_d   = now_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		p_d     = p_q;
		e_d     = e_q;
		left_d  = left_q;
		first_d = first_q;
		done_d  = done_q;
		clr_d   = clr_q;
		hw_we   = 1'b0;
		hw_addr = i_q;
		hw_data = e_q;
		hr_re   = 1'b0;
		hr_addr = i_q;
		pw_we   = 1'b0;
		pw_addr = e_q.h;
		pw_data = i_q;
		pr_re   = 1'b0;
		wr_d    = '0;
		wr_d.sum.count      = COUNT_W'(cnt_q);
		wr_d.sum.min_expiry = (cnt_q != '0) ? EXPIRY_W'(root_q) : '0;

		unique case (state_q)
			S_CLR: begin
				pw_we   = 1'b1;
				pw_addr = clr_q;
				pw_data = '0;
				clr_d   = clr_q + HB'(1);
				if (clr_q == HB'(HANDLES - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid && room) begin
					act_d   = req.action;
					hin_d   = req.handle;
					hx_d    = hxe[HB-1:0];
					hok_d   = hxe < HXW'(HANDLES);
					ex_d    = TIME_BITS'(ex_sat);
					now_d   = req.now;
					done_d  = '0;
					state_d = S_POS;
				end
			end
			S_POS: begin
				pr_re   = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_DONE;
				priority case (act_q)
					ACT_INSERT: begin
						if (!hok_q) begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_IGNORED, hin_q, '0, 1'b1);
						end else if (posv != '0) begin
							hr_re   = 1'b1;
							hr_addr = posv;
							state_d = S_INSX;
						end else if (cnt_q >= PB'(CAPACITY)) begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_FULL, hin_q, '0, 1'b1);
						end else begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_DONE, hin_q, EXPIRY_W'(ex_q), 1'b1);
							cnt_d   = cnt_q + PB'(1);
							i_d     = cnt_q + PB'(1);
							e_d.h   = hx_q;
							e_d.k   = ex_q;
							state_d = S_RS;
						end
					end
					ACT_DELETE: begin
						if (posv == '0) begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_IGNORED, hin_q, '0, 1'b1);
						end else begin
							hr_re   = 1'b1;
							hr_addr = posv;
							p_d     = posv;
							state_d = S_RMX;
						end
					end
					ACT_UPDATE: begin
						if (posv == '0) begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_IGNORED, hin_q, '0, 1'b1);
						end else begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_DONE, hin_q, EXPIRY_W'(ex_q), 1'b1);
							i_d     = posv;
							e_d.h   = hx_q;
							e_d.k   = ex_q;
							state_d = S_RS;
						end
					end
					ACT_POP: begin
						if (cnt_q == '0) begin
							wr_d.res_we = 1'b1;
							wr_d.res    = mk(ST_IGNORED, '0, '0, 1'b1);
						end else begin
							hr_re   = 1'b1;
							hr_addr = PB'(1);
							p_d     = PB'(1);
							state_d = S_RMX;
						end
					end
					ACT_SWEEP: state_d = S_SWCHK;
					default: begin
						wr_d.res_we = 1'b1;
						wr_d.res    = mk(ST_IGNORED, hin_q, '0, 1'b1);
					end
				endcase
			end
			S_INSX: begin
				wr_d.res_we = 1'b1;
				wr_d.res    = mk(ST_IGNORED, hin_q, EXPIRY_W'(h_rdata_q.k), 1'b1);
				state_d     = S_DONE;
			end
			S_RMX: begin
				wr_d.res_we = 1'b1;
				wr_d.res    = mk(ST_DONE, hout(h_rdata_q.h), EXPIRY_W'(h_rdata_q.k), 1'b1);
				pw_we   = 1'b1;
				pw_addr = h_rdata_q.h;
				pw_data = '0;
				hr_re   = 1'b1;
				hr_addr = cnt_q;
				state_d = S_RMLAST;
			end
			S_RMLAST: begin
				cnt_d = newcnt;
				if (p_q <= newcnt) begin
					e_d     = h_rdata_q;
					i_d     = p_q;
					state_d = S_RS;
				end else begin
					state_d = is_sweep ? S_SWCHK : S_DONE;
				end
			end
			S_RS: begin
				if (i_q > PB'(1)) begin
					hr_re   = 1'b1;
					hr_addr = i_q >> 1;
					first_d = 1'b1;
					state_d = S_UP;
				end else begin
					state_d = S_DN;
				end
			end
			S_UP: begin
				if (e_q.k < h_rdata_q.k) begin
					hw_we   = 1'b1;
					hw_data = h_rdata_q;
					pw_we   = 1'b1;
					pw_addr = h_rdata_q.h;
					i_d     = i_q >> 1;
					first_d = 1'b0;
					if ((i_q >> 1) > PB'(1)) begin
						hr_re   = 1'b1;
						hr_addr = i_q >> 2;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					state_d = first_q ? S_DN : S_FIN;
				end
			end
			S_DN: begin
				if (li <= {1'b0, cnt_q}) begin
					hr_re   = 1'b1;
					hr_addr = li[PB-1:0];
					state_d = S_DL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DL: begin
				left_d = h_rdata_q;
				if (li < {1'b0, cnt_q}) begin
					hr_re   = 1'b1;
					hr_addr = PB'({i_q, 1'b1});
					state_d = S_DR;
				end else if (e_q.k < h_rdata_q.k) begin
					state_d = S_FIN;
				end else begin
					hw_we   = 1'b1;
					hw_data = h_rdata_q;
					pw_we   = 1'b1;
					pw_addr = h_rdata_q.h;
					i_d     = li[PB-1:0];
					state_d = S_DN;
				end
			end
			S_DR: begin
				if (e_q.k < c_ent.k) begin
					state_d = S_FIN;
				end else begin
					hw_we   = 1'b1;
					hw_data = c_ent;
					pw_we   = 1'b1;
					pw_addr = c_ent.h;
					i_d     = c_idx[PB-1:0];
					state_d = S_DN;
				end
			end
			S_FIN: begin
				hw_we   = 1'b1;
				pw_we   = 1'b1;
				state_d = is_sweep ? S_SWCHK : S_DONE;
			end
			S_SWCHK: begin
				if (cnt_q != '0 && done_q < lim_q) begin
					hr_re   = 1'b1;
					hr_addr = PB'(1);
					p_d     = PB'(1);
					state_d = S_SWX;
				end else begin
					wr_d.res_we = 1'b1;
					wr_d.res    = mk(ST_END, '0, '0, 1'b1);
					state_d     = S_DONE;
				end
			end
			S_SWX: begin
				if (expired) begin
					wr_d.res_we = 1'b1;
					wr_d.res    = mk(ST_EXPIRED, hout(h_rdata_q.h), EXPIRY_W'(h_rdata_q.k),
						1'b0);
					done_d  = done_q + LIMIT_W'(1);
					pw_we   = 1'b1;
					pw_addr = h_rdata_q.h;
					pw_data = '0;
					hr_re   = 1'b1;
					hr_addr = cnt_q;
					state_d = S_RMLAST;
				end else begin
					wr_d.res_we = 1'b1;
					wr_d.res    = mk(ST_END, '0, '0, 1'b1);
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				wr_d.sum_we = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// heap slots and position table
	always_ff @(posedge clk) begin
		if (hw_we)
			heap_mem[hw_addr] <= hw_data;
		if (hr_re)
			h_rdata_q <= heap_mem[hr_addr];
		if (pw_we)
			pos_mem[pw_addr] <= pw_data;
		if (pr_re)
			p_rdata_q <= pos_mem[hx_q];
	end

	always_ff @(posedge clk) begin
		act_q   <= act_d;
		hin_q   <= hin_d;
		hx_q    <= hx_d;
		hok_q   <= hok_d;
		ex_q    <= ex_d;
		now_q   <= now_d;
		i_q     <= i_d;
		p_q     <= p_d;
		e_q     <= e_d;
		left_q  <= left_d;
		first_q <= first_d;
		done_q  <= done_d;
		if (hw_we && hw_addr == PB'(1))
			root_q <= hw_data.k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			clr_q   <= '0;
			lim_q   <= LIMIT_RST;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			clr_q   <= clr_d;
			if (cfg_we)
				lim_q <= cfg_wdata;
		end
	end

endmodule

/* rtl/tmh_rbuf.sv */
module tmh_rbuf (
	input  logic         clk,
	input  logic         arst_n,
	input  tmh_pkg::wr_t wr,
	output logic         room,
	tmh_rsp_if.source    rsp
);
	import tmh_pkg::*;

	localparam int AW = RES_AW;

	res_t           mem [RES_DEPTH];
	logic [AW:0]    wp_q, rp_q, used;
	res_t           rd_q, out_q;
	logic           rd_pend_q, ov_q;
	sum_t           sum_q [2];
	sum_t           outs_q;
	logic           swp_q, srp_q;
	logic [1:0]     scnt_q;
	logic           issue, pop;

	assign used  = wp_q - rp_q;
	assign room  = (used <= (AW+1)'(RES_DEPTH - MAX_RESULTS)) && (scnt_q < 2'd2);
	assign issue = !rd_pend_q && (wp_q != rp_q) && (scnt_q != 2'd0) && (!ov_q || rsp.ready);
	assign pop   = rd_pend_q && rd_q.last;

	assign rsp.valid      = ov_q;
	assign rsp.status     = out_q.status;
	assign rsp.out_handle = out_q.handle;
	assign rsp.out_expiry = out_q.expiry;
	assign rsp.last       = out_q.last;
	assign rsp.heap_count = outs_q.count;
	assign rsp.min_expiry = outs_q.min_expiry;

	always_ff @(posedge clk) begin
		if (wr.res_we)
			mem[wp_q[AW-1:0]] <= wr.res;
		if (issue)
			rd_q <= mem[rp_q[AW-1:0]];
		if (wr.sum_we)
			sum_q[swp_q] <= wr.sum;
		if (rd_pend_q) begin
			out_q  <= rd_q;
			outs_q <= sum_q[srp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			rd_pend_q <= 1'b0;
			ov_q      <= 1'b0;
			swp_q     <= 1'b0;
			srp_q     <= 1'b0;
			scnt_q    <= '0;
		end else begin
			if (wr.res_we)
				wp_q <= wp_q + (AW+1)'(1);
			if (issue)
				rp_q <= rp_q + (AW+1)'(1);
			rd_pend_q <= issue;
			if (rd_pend_q)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			if (wr.sum_we)
				swp_q <= ~swp_q;
			if (pop)
				srp_q <= ~srp_q;
			unique case ({wr.sum_we, pop})
				2'b10:   scnt_q <= scnt_q + 2'd1;
				2'b01:   scnt_q <= scnt_q - 2'd1;
				default: scnt_q <= scnt_q;
			endcase
		end
	end

endmodule

/* rtl/timer_min_heap.sv */
// Timer queue: a binary min-heap of handles ordered by expiry, with a
// per-handle position table.
// req carries one command word (action, handle, delay, now); rsp returns
// result words, each with heap_count and min_expiry as they stand after the
// whole command. Every command gives one word, a sweep gives one word per
// expired handle and an end word; last marks the final word of a command.
// cfg_we/cfg_wdata set the sweep limit (reset value 9).
// One command at a time; a command moves an entry up or down the heap level by
// level, and a sweep repeats the pop for each expired handle up to the sweep
// limit. Each level moved up costs one read of the heap memory, each level moved
// down up to two; the memory has one read and one write port. The buffer does
// not read a new result word while the previous read is still under way. After
// reset the position table is cleared entry by entry with req.ready low. A
// 128-word result buffer sits in front of rsp: a stalled receiver does not stop
// commands until fewer than 64 free words or two unread commands remain; rsp words hold while rsp.ready is low.
module timer_min_heap #(
	parameter int CAPACITY  = tmh_pkg::CAPACITY_DEF,
	parameter int HANDLES   = tmh_pkg::HANDLES_DEF,
	parameter int TIME_BITS = tmh_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tmh_req_if.sink                     req,
	tmh_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [tmh_pkg::LIMIT_W-1:0] cfg_wdata
);
	import tmh_pkg::*;

	wr_t  wr;
	logic room;

	tmh_ctrl #(
		.CAPACITY  (CAPACITY),
		.HANDLES   (HANDLES),
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.room      (room),
		.wr        (wr)
	);

	tmh_rbuf u_rbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.rsp    (rsp)
	);

endmodule

/* rtl/tmh_chk.sv */
module tmh_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [7:0]  rsp_out_handle,
	input logic        rsp_last,
	input logic [8:0]  rsp_heap_count,
	input logic [31:0] rsp_min_expiry
);
	import tmh_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_out_handle) && $stable(rsp_last))
		else $error("result word changed while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command taken while busy");

	a_exp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EXPIRED |-> !rsp_last)
		else $error("expired word marked last");

	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_heap_count == '0 |-> rsp_min_expiry == '0)
		else $error("empty heap with nonzero minimum");

endmodule

bind timer_min_heap tmh_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_out_handle (rsp.out_handle),
	.rsp_last       (rsp.last),
	.rsp_heap_count (rsp.heap_count),
	.rsp_min_expiry (rsp.min_expiry)
);
